### src/nor_flash_array_model_defines.svh
// assertion macros for the nor flash array model
// used by the top level only, expects clk and rst in scope
`ifndef NOR_FLASH_ARRAY_MODEL_DEFINES_SVH
`define NOR_FLASH_ARRAY_MODEL_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define NFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/nfa_pkg.sv
// shared types and constants for the nor flash array model
// no dependencies; imported by every module of the block
package nfa_pkg;

  // geometry
  localparam int BLOCK_W    = 4;
  localparam int PAGE_W     = 4;
  localparam int OFS_W      = 8;
  localparam int ADDR_W     = BLOCK_W + PAGE_W + OFS_W;
  localparam int BLK_OFS_W  = PAGE_W + OFS_W;
  localparam int MEM_DEPTH  = 1 << ADDR_W;
  localparam int MAX_BYTES  = 8;
  localparam int CNT_W      = 4;
  localparam int BIDX_W     = 3;
  localparam int RSV_W      = 5;
  localparam int DATA_W     = 8 * MAX_BYTES;

  localparam logic [7:0] ERASED = 8'hFF;

  // operation codes
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_PROG  = 2'd1;
  localparam logic [1:0] FUNC_ERASE = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ADDR = 2'd1;
  localparam logic [1:0] ST_PROG = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [BLOCK_W-1:0] block_index;
    logic [PAGE_W-1:0]  page_index;
    logic [OFS_W-1:0]   byte_offset;
    logic [DATA_W-1:0]  write_bytes;
    logic [CNT_W-1:0]   byte_count;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_bytes;
    logic [1:0]        status;
  } rsp_t;

  // sequencer to byte array
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

### src/nor_flash_array_model.sv
// top level of the nor flash array model: config register, sequencer, byte array
// depends on nfa_pkg, nfa_ctrl, nfa_mem and nor_flash_array_model_defines.svh
//
// A 64 KiB byte-wide flash array. After reset the block sweeps the whole array
// to 0xFF, one byte a cycle, and keeps busy high throughout the sweep. A
// transaction is taken when start is high and busy is low; its result appears
// on result for the single cycle that done is high and must be captured then,
// since the receiver cannot stall the block. All array traffic goes through
// one byte port under a small sequencer: a read fetches its n bytes, a program
// reads them to check that it only clears bits, then writes them unless
// refused, an erase writes 0xFF to one byte of the block per cycle, and an
// access with an address error or zero count goes to done. The user must write
// reserved_blocks via cfg_valid/cfg_data only when idle, unchecked by the block.
module nor_flash_array_model (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  nfa_pkg::cmd_t             cmd,
  output logic                      done,
  output nfa_pkg::rsp_t             result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [nfa_pkg::RSV_W-1:0] cfg_data
);
  import nfa_pkg::*;
  `include "nor_flash_array_model_defines.svh"

  logic [RSV_W-1:0] reserved_blocks;
  mem_req_t         mem_req;
  logic [7:0]       mem_rdata;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_blocks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      reserved_blocks <= cfg_data;
    end
  end

  nfa_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .cmd             (cmd),
    .reserved_blocks (reserved_blocks),
    .mem_rdata       (mem_rdata),
    .mem_req         (mem_req),
    .busy            (busy),
    .done            (done),
    .result          (result)
  );

  nfa_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // checks
  `NFA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `NFA_ASSERT_NXT(a_done_pulse, done, !done && !busy, "result strobe longer than one cycle")
  `NFA_ASSERT_IMP(a_done_busy, done, busy, "result strobe while idle")
  `NFA_ASSERT_IMP(a_err_zero, done && result.status != ST_OK, result.read_bytes == '0,
                  "error result carries read data")

endmodule

### src/nfa_mem.sv
// byte array of the flash: one write and one registered read per cycle
// depends on nfa_pkg
module nfa_mem (
  input  logic              clk,
  input  nfa_pkg::mem_req_t req,
  output logic [7:0]        rdata
);
  import nfa_pkg::*;

  logic [7:0] mem [MEM_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

### src/nfa_ctrl.sv
// sequencer of the flash model: address check, byte reads, program check,
// byte writes, block erase and the clearing sweep; depends on nfa_pkg
module nfa_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  nfa_pkg::cmd_t             cmd,
  input  logic [nfa_pkg::RSV_W-1:0] reserved_blocks,
  input  logic [7:0]                mem_rdata,
  output nfa_pkg::mem_req_t         mem_req,
  output logic                      busy,
  output logic                      done,
  output nfa_pkg::rsp_t             result
);
  import nfa_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_WRITE = 6'b001000,
    S_ERASE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  sweep;
  logic [ADDR_W-1:0]  base;
  logic [BLOCK_W-1:0] blk;
  logic [1:0]         func;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   idx;
  logic [DATA_W-1:0]  wbytes;
  logic [DATA_W-1:0]  rbuf;
  logic               rd_pend;
  logic [BIDX_W-1:0]  rd_idx;
  logic               viol;
  logic [1:0]         status;

  logic [ADDR_W-1:0]  in_addr;
  logic [CNT_W-1:0]   in_cnt;
  logic [ADDR_W:0]    in_end;
  logic               blk_rsv;
  logic               addr_bad;
  logic               accept;
  logic               rd_last;
  logic [7:0]         chk_byte;
  logic [ADDR_W-1:0]  cur_addr;

  // address check on the incoming transaction
  always_comb begin
    in_addr  = {cmd.block_index, cmd.page_index, cmd.byte_offset};
    in_cnt   = (cmd.byte_count > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : cmd.byte_count;
    in_end   = {1'b0, in_addr} + (ADDR_W+1)'(in_cnt);
    blk_rsv  = {1'b0, cmd.block_index} < reserved_blocks;
    addr_bad = blk_rsv || (in_end > (ADDR_W+1)'(MEM_DEPTH));
    accept   = start && (state == S_IDLE);
  end

  assign rd_last  = (idx == cnt) && !rd_pend;
  assign chk_byte = wbytes[rd_idx*8 +: 8];
  assign cur_addr = base + ADDR_W'(idx);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sweep == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (cmd.func)
            FUNC_READ, FUNC_PROG: begin
              if (addr_bad || in_cnt == '0) state_next = S_DONE;
              else                          state_next = S_READ;
            end
            FUNC_ERASE: begin
              if (blk_rsv) state_next = S_DONE;
              else         state_next = S_ERASE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_READ: begin
        if (rd_last) begin
          if (func == FUNC_PROG && !viol) state_next = S_WRITE;
          else                            state_next = S_DONE;
        end
      end
      S_WRITE: begin
        if (CNT_W'(idx + 1'b1) == cnt) state_next = S_DONE;
      end
      S_ERASE: begin
        if (sweep[BLK_OFS_W-1:0] == '1) state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = cur_addr;
    mem_req.wdata = wbytes[idx[BIDX_W-1:0]*8 +: 8];
    mem_req.raddr = cur_addr;
    unique case (state)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep;
        mem_req.wdata = ERASED;
      end
      S_WRITE: mem_req.we = 1'b1;
      S_ERASE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {blk, sweep[BLK_OFS_W-1:0]};
        mem_req.wdata = ERASED;
      end
      default: mem_req.we = 1'b0;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      sweep   <= '0;
      rd_pend <= 1'b0;
      idx     <= '0;
      viol    <= 1'b0;
      status  <= ST_OK;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: sweep <= sweep + 1'b1;
        S_IDLE: begin
          if (accept) begin
            base    <= in_addr;
            blk     <= cmd.block_index;
            func    <= cmd.func;
            cnt     <= in_cnt;
            wbytes  <= cmd.write_bytes;
            rbuf    <= '0;
            idx     <= '0;
            sweep   <= '0;
            viol    <= 1'b0;
            rd_pend <= 1'b0;
            if ((cmd.func == FUNC_READ || cmd.func == FUNC_PROG) && addr_bad) begin
              status <= ST_ADDR;
            end else if (cmd.func == FUNC_ERASE && blk_rsv) begin
              status <= ST_ADDR;
            end else begin
              status <= ST_OK;
            end
          end
        end
        S_READ: begin
          // issue one byte read a cycle
          if (idx != cnt) begin
            idx     <= idx + 1'b1;
            rd_pend <= 1'b1;
            rd_idx  <= idx[BIDX_W-1:0];
          end else begin
            rd_pend <= 1'b0;
          end
          // capture returned byte, check that a program only clears bits
          if (rd_pend) begin
            if (func == FUNC_READ) rbuf[rd_idx*8 +: 8] <= mem_rdata;
            viol <= viol | (|(chk_byte & ~mem_rdata));
          end
          if (rd_last) begin
            idx <= '0;
            if (func == FUNC_PROG && viol) status <= ST_PROG;
          end
        end
        S_WRITE: idx <= idx + 1'b1;
        S_ERASE: sweep <= sweep + 1'b1;
        S_DONE:  idx <= '0;
        default: idx <= '0;
      endcase
    end
  end

  assign busy              = (state != S_IDLE);
  assign done              = (state == S_DONE);
  assign result.read_bytes = rbuf;
  assign result.status     = status;

endmodule
